/* rtl/mcr_pkg.sv */
// Package for the midpoint circle rasterizer: shared constants, the controller
// state type and the command and status structs between controller and datapath.
// No dependencies.
package mcr_pkg;

  // Default bounds handed to the top-level parameters.
  localparam int MAX_RADIUS_DEF = 63;
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  // Field widths fixed by the interface.
  localparam int COORD_W  = 12;
  localparam int RADIUS_W = 6;
  localparam int COLOR_W  = 32;
  localparam int CFG_W    = 11;
  localparam int ADDR_W   = 20;
  localparam int LANES    = 8;

  // Configuration register indexes and reset values.
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;
  localparam logic [CFG_W-1:0] IMAGE_WIDTH_RST  = 11'd640;
  localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RST = 11'd480;

  // Results per circle are capped.
  localparam int RESULT_CAP = 48;
  localparam int CNT_W      = $clog2(RESULT_CAP);

  // Decision-variable constants of the circle recurrence.
  localparam int DEC_INIT     = 3;
  localparam int DEC_RAD_MUL  = 2;
  localparam int DEC_STEP_MUL = 4;
  localparam int DEC_DIAG_ADD = 10;
  localparam int DEC_AXIS_ADD = 6;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } mcr_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;    // latch a new command and set up the first point
    logic capture;  // register the current point's rows and columns, then advance
    logic load_out; // move the captured point into the output register
    logic last;     // last marker of the point being loaded
  } mcr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic y_ge_x;   // current point still lies in the first octant
  } mcr_sts_t;

endpackage

/* rtl/mcr_ctrl.sv */
// Controller of the midpoint circle rasterizer: command acceptance, the step
// counter and the valid bits of the address pipeline and output register.
// Depends on mcr_pkg.
module mcr_ctrl
  import mcr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  mcr_sts_t sts,
  output mcr_cmd_t cmd
);

  mcr_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             gen_left_r, gen_left_nxt;
  logic             a_vld_r, a_vld_nxt;
  logic             a_last_r, a_last_nxt;
  logic             out_vld_r, out_vld_nxt;

  logic load;
  logic cap;
  logic last_pt;

  // State and valid registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      cnt_r      <= '0;
      gen_left_r <= 1'b0;
      a_vld_r    <= 1'b0;
      a_last_r   <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      gen_left_r <= gen_left_nxt;
      a_vld_r    <= a_vld_nxt;
      a_last_r   <= a_last_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // The output register takes a point when it is empty or its beat leaves.
  assign load    = a_vld_r && (!out_vld_r || out_ready);
  assign last_pt = !sts.y_ge_x || (cnt_r == CNT_W'(RESULT_CAP - 1));

  // Next state and commands.
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    gen_left_nxt = gen_left_r;
    a_vld_nxt    = a_vld_r;
    a_last_nxt   = a_last_r;
    cap          = 1'b0;
    in_ready     = 1'b0;
    cmd          = '0;

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start    = 1'b1;
          state_nxt    = ST_RUN;
          cnt_nxt      = '0;
          gen_left_nxt = 1'b1;
        end
      end
      ST_RUN: begin
        cap = gen_left_r && (!a_vld_r || load);
        if (cap) begin
          cnt_nxt    = cnt_r + 1'b1;
          a_vld_nxt  = 1'b1;
          a_last_nxt = last_pt;
          if (last_pt) begin
            gen_left_nxt = 1'b0;
          end
        end else if (load) begin
          a_vld_nxt = 1'b0;
        end
        if (load && a_last_r) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    cmd.capture  = cap;
    cmd.load_out = load;
    cmd.last     = a_last_r;
  end

  // Output valid follows loads and completed beats.
  always_comb begin
    if (load) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  assign out_valid = out_vld_r;

endmodule

/* rtl/mcr_datapath.sv */
// Datapath of the midpoint circle rasterizer: the point and decision registers,
// the row-product stage and the address, mask and output registers.
// Depends on mcr_pkg.
module mcr_datapath
  import mcr_pkg::*;
#(
  parameter int MAX_RADIUS = MAX_RADIUS_DEF,
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                       clk,
  input  mcr_cmd_t                   cmd,
  output mcr_sts_t                   sts,
  input  logic [CFG_W-1:0]           image_width,
  input  logic [CFG_W-1:0]           image_height,
  input  logic signed [COORD_W-1:0]  in_center_x,
  input  logic signed [COORD_W-1:0]  in_center_y,
  input  logic [RADIUS_W-1:0]        in_radius,
  input  logic [COLOR_W-1:0]         in_color,
  output logic [ADDR_W-1:0]          out_addr [LANES],
  output logic [LANES-1:0]           out_write_mask,
  output logic [COLOR_W-1:0]         out_pixel_value,
  output logic                       out_last_step
);

  // Point offsets reach the radius plus one, the decision about eight radii.
  localparam int RW = $clog2(MAX_RADIUS + 1);
  localparam int OW = RW + 2;
  localparam int DW = RW + 6;
  localparam int CW = ((OW > COORD_W) ? OW : COORD_W) + 1;
  localparam int PW = CW + CFG_W + 1;
  localparam int IW = PW + 1;
  localparam int LW = 2 * CFG_W;

  localparam logic signed [DW-1:0] K_INIT = DW'(DEC_INIT);
  localparam logic signed [DW-1:0] K_RAD  = DW'(DEC_RAD_MUL);
  localparam logic signed [DW-1:0] K_STEP = DW'(DEC_STEP_MUL);
  localparam logic signed [DW-1:0] K_DIAG = DW'(DEC_DIAG_ADD);
  localparam logic signed [DW-1:0] K_AXIS = DW'(DEC_AXIS_ADD);

  logic signed [OW-1:0]      x_r, y_r;
  logic signed [DW-1:0]      d_r;
  logic signed [COORD_W-1:0] cx_r, cy_r;
  logic [COLOR_W-1:0]        color_r;
  logic signed [PW-1:0]      prod_r [4];
  logic signed [CW-1:0]      col_r  [4];
  logic [LW-1:0]             limit_r;
  logic [ADDR_W-1:0]         addr_r [LANES];
  logic [LANES-1:0]          mask_r;
  logic [COLOR_W-1:0]        pix_r;
  logic                      last_r;

  logic [CFG_W-1:0]     w_eff, h_eff;
  logic signed [CFG_W:0] w_s;
  logic signed [OW-1:0] r_eff;
  logic signed [OW-1:0] x_inc, y_dec;
  logic signed [DW-1:0] d_nxt;
  logic signed [CW-1:0] row [4];
  logic signed [CW-1:0] col [4];
  logic signed [IW-1:0] idx [LANES];
  logic signed [IW-1:0] lim_s;

  // Clamp the geometry and the radius to the configured bounds.
  assign w_eff = (32'(image_width) > MAX_WIDTH) ? CFG_W'(MAX_WIDTH) : image_width;
  assign h_eff = (32'(image_height) > MAX_HEIGHT) ? CFG_W'(MAX_HEIGHT) : image_height;
  assign w_s   = $signed({1'b0, w_eff});
  assign r_eff = (32'(in_radius) > MAX_RADIUS) ? OW'(MAX_RADIUS) : OW'(in_radius);

  // Size must only change while idle (unenforced); one register stage is enough.
  always_ff @(posedge clk) begin
    limit_r <= LW'(w_eff) * LW'(h_eff);
  end

  // Next point of the circle recurrence.
  assign x_inc = x_r + OW'(1);
  assign y_dec = y_r - OW'(1);
  always_comb begin
    if (d_r > 0) begin
      d_nxt = d_r + K_STEP * DW'(x_inc - y_dec) + K_DIAG;
    end else begin
      d_nxt = d_r + K_STEP * DW'(x_inc) + K_AXIS;
    end
  end
  assign sts.y_ge_x = (y_r >= x_r);

  // Rows and columns of the eight mirrored points share four values each.
  assign row[0] = CW'(cy_r) + CW'(y_r);
  assign row[1] = CW'(cy_r) - CW'(y_r);
  assign row[2] = CW'(cy_r) + CW'(x_r);
  assign row[3] = CW'(cy_r) - CW'(x_r);
  assign col[0] = CW'(cx_r) + CW'(x_r);
  assign col[1] = CW'(cx_r) - CW'(x_r);
  assign col[2] = CW'(cx_r) + CW'(y_r);
  assign col[3] = CW'(cx_r) - CW'(y_r);

  // Command latch, point registers and the row-product stage.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cx_r    <= in_center_x;
      cy_r    <= in_center_y;
      color_r <= in_color;
      x_r     <= '0;
      y_r     <= r_eff;
      d_r     <= K_INIT - K_RAD * DW'(r_eff);
    end else if (cmd.capture) begin
      for (int k = 0; k < 4; k++) begin
        prod_r[k] <= PW'(row[k]) * PW'(w_s);
        col_r[k]  <= col[k];
      end
      x_r <= x_inc;
      if (d_r > 0) begin
        y_r <= y_dec;
      end
      d_r <= d_nxt;
    end
  end

  // Linear addresses: row product plus column, lanes in port order.
  assign idx[0] = IW'(prod_r[0]) + IW'(col_r[0]);
  assign idx[1] = IW'(prod_r[0]) + IW'(col_r[1]);
  assign idx[2] = IW'(prod_r[1]) + IW'(col_r[0]);
  assign idx[3] = IW'(prod_r[1]) + IW'(col_r[1]);
  assign idx[4] = IW'(prod_r[2]) + IW'(col_r[2]);
  assign idx[5] = IW'(prod_r[2]) + IW'(col_r[3]);
  assign idx[6] = IW'(prod_r[3]) + IW'(col_r[2]);
  assign idx[7] = IW'(prod_r[3]) + IW'(col_r[3]);
  assign lim_s  = IW'($signed({1'b0, limit_r}));

  // Output register: truncated addresses, range mask, colour and last marker.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      for (int i = 0; i < LANES; i++) begin
        addr_r[i] <= idx[i][ADDR_W-1:0];
        mask_r[i] <= (idx[i] >= 0) && (idx[i] < lim_s);
      end
      pix_r  <= color_r;
      last_r <= cmd.last;
    end
  end

  assign out_addr        = addr_r;
  assign out_write_mask  = mask_r;
  assign out_pixel_value = pix_r;
  assign out_last_step   = last_r;

endmodule

/* rtl/midpoint_circle_rasterizer.sv */
// Top level of the midpoint circle rasterizer: configuration registers on the
// APB-style port and the controller and datapath. Depends on mcr_pkg,
// mcr_ctrl and mcr_datapath.
//
// The block takes one circle command (centre, radius, colour) and returns one
// result beat per point of the midpoint circle walk, starting at (0, radius)
// and ending with the first point past the octant boundary, at most 48 beats,
// the final one flagged by out_last_step. Each beat carries the eight mirrored
// linear addresses (row times width plus column, truncated to 20 bits, so a
// column off the edge wraps into the next row), a mask of the lanes that lie
// inside width times height, and the colour. Without back-pressure a circle of
// radius r delivers one beat per cycle, about 0.71*r + 2 beats, and the first
// beat goes in order through the point registers, which take the command at
// the accepting edge, then through the registers of the row-product
// multiplier stage and the output register. A new command is taken from
// the cycle after the final beat of the previous circle enters the output
// register. Width and height are written at byte addresses 0 and 4 and must
// only change while no circle is in progress.
module midpoint_circle_rasterizer
  import mcr_pkg::*;
#(
  parameter int MAX_RADIUS = MAX_RADIUS_DEF,
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // Configuration port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  // Command channel
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COORD_W-1:0] in_center_x,
  input  logic signed [COORD_W-1:0] in_center_y,
  input  logic [RADIUS_W-1:0]       in_radius,
  input  logic [COLOR_W-1:0]        in_color,
  // Result channel
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [ADDR_W-1:0]         out_addr_px_py,
  output logic [ADDR_W-1:0]         out_addr_mx_py,
  output logic [ADDR_W-1:0]         out_addr_px_my,
  output logic [ADDR_W-1:0]         out_addr_mx_my,
  output logic [ADDR_W-1:0]         out_addr_py_px,
  output logic [ADDR_W-1:0]         out_addr_my_px,
  output logic [ADDR_W-1:0]         out_addr_py_mx,
  output logic [ADDR_W-1:0]         out_addr_my_mx,
  output logic [LANES-1:0]          out_write_mask,
  output logic [COLOR_W-1:0]        out_pixel_value,
  output logic                      out_last_step
);

  logic [CFG_W-1:0]  image_width_r;
  logic [CFG_W-1:0]  image_height_r;
  logic              cfg_wr;
  mcr_cmd_t          cmd;
  mcr_sts_t          sts;
  logic [ADDR_W-1:0] addr [LANES];

  // Register writes complete in the access phase; the port never waits.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= IMAGE_WIDTH_RST;
      image_height_r <= IMAGE_HEIGHT_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_IMAGE_WIDTH:  image_width_r  <= pwdata[CFG_W-1:0];
        REG_IMAGE_HEIGHT: image_height_r <= pwdata[CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Read-back of the selected register.
  always_comb begin
    case (paddr[2])
      REG_IMAGE_WIDTH:  prdata = {{(32-CFG_W){1'b0}}, image_width_r};
      REG_IMAGE_HEIGHT: prdata = {{(32-CFG_W){1'b0}}, image_height_r};
      default:          prdata = '0;
    endcase
  end

  mcr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mcr_datapath #(
    .MAX_RADIUS (MAX_RADIUS),
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk             (clk),
    .cmd             (cmd),
    .sts             (sts),
    .image_width     (image_width_r),
    .image_height    (image_height_r),
    .in_center_x     (in_center_x),
    .in_center_y     (in_center_y),
    .in_radius       (in_radius),
    .in_color        (in_color),
    .out_addr        (addr),
    .out_write_mask  (out_write_mask),
    .out_pixel_value (out_pixel_value),
    .out_last_step   (out_last_step)
  );

  // Lanes onto their named ports.
  assign out_addr_px_py = addr[0];
  assign out_addr_mx_py = addr[1];
  assign out_addr_px_my = addr[2];
  assign out_addr_mx_my = addr[3];
  assign out_addr_py_px = addr[4];
  assign out_addr_my_px = addr[5];
  assign out_addr_py_mx = addr[6];
  assign out_addr_my_mx = addr[7];

endmodule

/* rtl/mcr_checker.sv */
// Port-level checker for the midpoint circle rasterizer and the bind that
// attaches it to the top level. Depends on mcr_pkg and midpoint_circle_rasterizer.
module mcr_checker
  import mcr_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [ADDR_W-1:0]  out_addr_px_py,
  input logic [LANES-1:0]   out_write_mask,
  input logic [COLOR_W-1:0] out_pixel_value,
  input logic               out_last_step
);

  // A stalled result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_addr_px_py)
      && $stable(out_write_mask) && $stable(out_last_step))
    else $error("result beat changed while stalled");

  // An accepted command beat starts a circle, so no second command follows at once.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("command accepted on two consecutive cycles");

  // While a non-final point waits at the output the circle is still running.
  a_no_accept_mid_circle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_step |-> !in_ready)
    else $error("command taken before the final point was produced");

  // All points of one circle carry the same colour.
  a_colour_steady: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_step |=> $stable(out_pixel_value))
    else $error("colour changed within a circle");

endmodule

bind midpoint_circle_rasterizer mcr_checker u_mcr_checker (.*);
